// ===== rtl/ise_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ise_pkg: shared types and constants for the interval set engine
// Table size, field widths, request codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ise_pkg;

  localparam int MAX_RANGES = 16;
  localparam int IDX_W      = 31;
  localparam int ADDR_W     = $clog2(MAX_RANGES);
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int MEM_DEPTH  = 2 * MAX_RANGES;

  // request codes
  localparam logic [2:0] FUNC_ADD     = 3'd0;
  localparam logic [2:0] FUNC_SUB     = 3'd1;
  localparam logic [2:0] FUNC_CLEAR   = 3'd2;
  localparam logic [2:0] FUNC_ENFORCE = 3'd3;
  localparam logic [2:0] FUNC_READ    = 3'd4;
  localparam logic [2:0] FUNC_CONT    = 3'd5;

  // selection types
  localparam logic [2:0] SEL_NONE   = 3'd0;
  localparam logic [2:0] SEL_SINGLE = 3'd2;
  localparam logic [2:0] SEL_RANGE  = 3'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_BAD_IDX = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN, S_TAIL, S_ENF2, S_ENF3A, S_ENF3B, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    RD_ZERO, RD_IDX, RD_LAST, RD_NEXT, RD_HOLD
  } rd_sel_t;

  typedef struct packed {
    logic    capture;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    scan;
    logic    tail;
    logic    enf2;
    logic    enf3a;
    logic    enf3b;
    logic    finish;
  } ise_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic [2:0] sel;
    logic       invalid;
    logic       empty;
    logic       cnt_zero;
    logic       cnt_gt1;
    logic       adv;
    logic       last;
    logic       out_free;
  } ise_stat_t;

endpackage

// ===== rtl/ise_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ise_ctrl: request sequencer
// Decodes the captured request and walks the datapath through the table
// scan, the tail write, the enforce steps and the result hand-off.
// ----------------------------------------------------------------------------
module ise_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ise_pkg::ise_stat_t st,
  output ise_pkg::ise_cmd_t  cmd
);
  import ise_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_ZERO;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FIN;
        case (st.func)
          FUNC_ADD: begin
            if (!st.invalid && !st.empty) begin
              if (st.cnt_zero) begin
                state_next = S_TAIL;
              end else begin
                cmd.rd_en  = 1'b1;
                state_next = S_SCAN;
              end
            end
          end
          FUNC_SUB, FUNC_CONT: begin
            if (!st.invalid && !st.empty && !st.cnt_zero) begin
              cmd.rd_en  = 1'b1;
              state_next = S_SCAN;
            end
          end
          FUNC_READ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX;
          end
          FUNC_ENFORCE: begin
            if (st.sel == SEL_SINGLE && !st.cnt_zero) begin
              cmd.rd_en  = 1'b1;
              state_next = S_ENF2;
            end else if (st.sel == SEL_RANGE && st.cnt_gt1) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_LAST;
              state_next = S_ENF3A;
            end
          end
          default: state_next = S_FIN;
        endcase
      end
      S_SCAN: begin
        cmd.scan   = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = st.adv ? RD_NEXT : RD_HOLD;
        if (st.adv && st.last) begin
          state_next = (st.func == FUNC_ADD) ? S_TAIL : S_FIN;
        end
      end
      S_TAIL: begin
        cmd.tail   = 1'b1;
        state_next = S_FIN;
      end
      S_ENF2: begin
        cmd.enf2   = 1'b1;
        state_next = S_FIN;
      end
      S_ENF3A: begin
        cmd.enf3a  = 1'b1;
        cmd.rd_en  = 1'b1;
        state_next = S_ENF3B;
      end
      S_ENF3B: begin
        cmd.enf3b  = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/ise_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ise_dpath: interval table datapath
// Two-bank range table, request registers, per-entry merge/trim logic,
// running point sum and the result register.
// ----------------------------------------------------------------------------
module ise_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  ise_pkg::ise_cmd_t           cmd,
  output ise_pkg::ise_stat_t          st,
  input  logic [2:0]                  func,
  input  logic [ise_pkg::IDX_W-1:0]   req_begin,
  input  logic [ise_pkg::IDX_W-1:0]   req_end,
  input  logic [2:0]                  sel_type,
  input  logic [3:0]                  entry_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ise_pkg::CNT_W-1:0]   range_count,
  output logic [ise_pkg::IDX_W-1:0]   point_total,
  output logic [ise_pkg::IDX_W-1:0]   read_begin,
  output logic [ise_pkg::IDX_W-1:0]   read_end,
  output logic                        is_contained,
  output logic [1:0]                  status
);
  import ise_pkg::*;

  // table: bank bit on top selects live or scratch half
  logic [IDX_W-1:0] bmem [MEM_DEPTH];
  logic [IDX_W-1:0] emem [MEM_DEPTH];

  logic [2:0]        func_q, sel_q;
  logic [IDX_W-1:0]  b_q, e_q;
  logic [3:0]        idx_q;
  logic              bank;
  logic [CNT_W-1:0]  count, k;
  logic [IDX_W-1:0]  psum, acc;
  logic [ADDR_W-1:0] ptr, raddr;
  logic [IDX_W-1:0]  nb, ne, rd_b, rd_e;
  logic              placed, half, ovf, cont;

  logic              step_wr, step_adv, merge, set_placed, set_half, clr_half;
  logic [IDX_W-1:0]  step_b, step_e, dest_b, dest_e, wr_b, wr_e;
  logic              dest_wr, kfull, mem_we;
  logic [ADDR_W:0]   mem_wa;
  logic              invalid, empty, idx_ok, is_addsub, apply, clear_now;
  logic [CNT_W-1:0]  count_fin;
  logic [IDX_W-1:0]  psum_fin;
  logic [1:0]        status_fin;

  assign invalid   = e_q < b_q;
  assign empty     = e_q == b_q;
  assign idx_ok    = 32'(idx_q) < 32'(count);
  assign is_addsub = (func_q == FUNC_ADD) || (func_q == FUNC_SUB);
  assign kfull     = k == CNT_W'(MAX_RANGES);

  // status toward the sequencer
  always_comb begin
    st.func     = func_q;
    st.sel      = sel_q;
    st.invalid  = invalid;
    st.empty    = empty;
    st.cnt_zero = count == '0;
    st.cnt_gt1  = count > CNT_W'(1);
    st.adv      = step_adv;
    st.last     = CNT_W'(ptr) == count - CNT_W'(1);
    st.out_free = !out_valid || out_ready;
  end

  // per-entry step: copy, merge, place merged range, trim or drop
  always_comb begin
    step_wr    = 1'b0;
    step_adv   = 1'b0;
    step_b     = rd_b;
    step_e     = rd_e;
    merge      = 1'b0;
    set_placed = 1'b0;
    set_half   = 1'b0;
    clr_half   = 1'b0;
    case (func_q)
      FUNC_ADD: begin
        if (rd_e < b_q) begin
          step_wr  = 1'b1;
          step_adv = 1'b1;
        end else if (rd_b <= e_q) begin
          merge    = 1'b1;
          step_adv = 1'b1;
        end else if (!placed) begin
          step_wr    = 1'b1;
          step_b     = nb;
          step_e     = ne;
          set_placed = 1'b1;
        end else begin
          step_wr  = 1'b1;
          step_adv = 1'b1;
        end
      end
      FUNC_SUB: begin
        if (rd_e <= b_q || rd_b >= e_q) begin
          step_wr  = 1'b1;
          step_adv = 1'b1;
        end else if (rd_b < b_q && !half) begin
          step_wr = 1'b1;
          step_e  = b_q;
          if (rd_e > e_q) begin
            set_half = 1'b1;
          end else begin
            step_adv = 1'b1;
          end
        end else if (rd_e > e_q) begin
          step_wr  = 1'b1;
          step_b   = e_q;
          step_adv = 1'b1;
          clr_half = 1'b1;
        end else begin
          step_adv = 1'b1;
        end
      end
      default: step_adv = 1'b1;
    endcase
  end

  // scratch-bank write from scan or tail
  assign dest_wr = (cmd.scan && step_wr) || (cmd.tail && !placed);
  assign dest_b  = cmd.tail ? nb : step_b;
  assign dest_e  = cmd.tail ? ne : step_e;

  // memory write port mux
  always_comb begin
    mem_we = (dest_wr && !kfull) || cmd.enf2 || cmd.enf3b;
    mem_wa = {~bank, k[ADDR_W-1:0]};
    wr_b   = dest_b;
    wr_e   = dest_e;
    if (cmd.enf2) begin
      mem_wa = {bank, ADDR_W'(0)};
      wr_b   = rd_b;
      wr_e   = (rd_e > rd_b + IDX_W'(1)) ? rd_b + IDX_W'(1) : rd_e;
    end else if (cmd.enf3b) begin
      mem_wa = {bank, ADDR_W'(0)};
      wr_b   = rd_b;
      wr_e   = ne;
    end
  end

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      RD_ZERO: raddr = '0;
      RD_IDX:  raddr = ADDR_W'(idx_q);
      RD_LAST: raddr = ADDR_W'(count - CNT_W'(1));
      RD_NEXT: raddr = ptr + ADDR_W'(1);
      RD_HOLD: raddr = ptr;
      default: raddr = ptr;
    endcase
  end

  // table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bmem[mem_wa] <= wr_b;
      emem[mem_wa] <= wr_e;
    end
    if (cmd.rd_en) begin
      rd_b <= bmem[{bank, raddr}];
      rd_e <= emem[{bank, raddr}];
    end
  end

  // results at hand-off
  always_comb begin
    apply     = is_addsub && !invalid && !empty && !ovf;
    clear_now = (func_q == FUNC_CLEAR) ||
                (func_q == FUNC_ENFORCE && sel_q == SEL_NONE);
    count_fin = apply ? k : (clear_now ? '0 : count);
    psum_fin  = apply ? acc : (clear_now ? '0 : psum);
    status_fin = ST_OK;
    if ((is_addsub || func_q == FUNC_CONT) && invalid) begin
      status_fin = ST_INVALID;
    end else if (func_q == FUNC_READ && !idx_ok) begin
      status_fin = ST_BAD_IDX;
    end else if (apply == 1'b0 && is_addsub && !invalid && !empty) begin
      status_fin = ST_FULL;
    end
  end

  // request registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= func;
      b_q    <= req_begin;
      e_q    <= req_end;
      sel_q  <= sel_type;
      idx_q  <= entry_index;
    end
  end

  // merged range and enforce scratch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      nb <= req_begin;
      ne <= req_end;
    end else if (cmd.scan && merge) begin
      if (rd_b < nb) nb <= rd_b;
      if (rd_e > ne) ne <= rd_e;
    end else if (cmd.enf3a) begin
      ne <= rd_e;
    end
  end

  // control and table state
  always_ff @(posedge clk) begin
    if (rst) begin
      bank      <= 1'b0;
      count     <= '0;
      psum      <= '0;
      k         <= '0;
      acc       <= '0;
      ptr       <= '0;
      placed    <= 1'b0;
      half      <= 1'b0;
      ovf       <= 1'b0;
      cont      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        k      <= '0;
        acc    <= '0;
        ptr    <= '0;
        placed <= 1'b0;
        half   <= 1'b0;
        ovf    <= 1'b0;
        cont   <= 1'b0;
      end
      if (cmd.scan) begin
        if (step_adv) ptr <= ptr + ADDR_W'(1);
        if (set_placed) placed <= 1'b1;
        if (set_half) half <= 1'b1;
        if (clr_half) half <= 1'b0;
        if (func_q == FUNC_CONT && rd_b <= b_q && rd_e >= e_q) cont <= 1'b1;
      end
      if (cmd.tail) placed <= 1'b1;
      if (dest_wr) begin
        if (kfull) begin
          ovf <= 1'b1;
        end else begin
          k   <= k + CNT_W'(1);
          acc <= acc + (dest_e - dest_b);
        end
      end
      // enforce single point / one range
      if (cmd.enf2) begin
        count <= CNT_W'(1);
        psum  <= IDX_W'(1);
      end
      if (cmd.enf3b) begin
        count <= CNT_W'(1);
        psum  <= ne - rd_b;
      end
      // commit and output valid
      if (cmd.finish) begin
        count     <= count_fin;
        psum      <= psum_fin;
        if (apply) bank <= ~bank;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      range_count  <= count_fin;
      point_total  <= psum_fin;
      read_begin   <= (func_q == FUNC_READ && idx_ok) ? rd_b : '0;
      read_end     <= (func_q == FUNC_READ && idx_ok) ? rd_e : '0;
      is_contained <= (func_q == FUNC_CONT) && cont;
      status       <= status_fin;
    end
  end

endmodule

// ===== rtl/interval_set_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_set_engine_top: sorted disjoint interval set engine
// Stores up to 16 sorted, disjoint half-open ranges; each request adds,
// subtracts, clears, enforces a selection type, reads or queries the set.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | func, req_begin, req_end, sel_type,
//          |                      | entry_index
//  out     | out_valid / out_ready| range_count, point_total, read_begin,
//          |                      | read_end, is_contained, status
//
// Add, subtract and contains walk the table one entry a cycle through the
// single read port, holding on an entry while a merged range is placed ahead
// of it or while it is split; add then writes the merged range at the tail
// if it was not yet placed. Clear, read and enforce need no table walk.
// One request is in flight at a time; a waiting result holds in the output
// register and the next request is taken once the engine returns to idle.
// Reset empties the set at once.
// ----------------------------------------------------------------------------
module interval_set_engine_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  func,
  input  logic [ise_pkg::IDX_W-1:0]   req_begin,
  input  logic [ise_pkg::IDX_W-1:0]   req_end,
  input  logic [2:0]                  sel_type,
  input  logic [3:0]                  entry_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ise_pkg::CNT_W-1:0]   range_count,
  output logic [ise_pkg::IDX_W-1:0]   point_total,
  output logic [ise_pkg::IDX_W-1:0]   read_begin,
  output logic [ise_pkg::IDX_W-1:0]   read_end,
  output logic                        is_contained,
  output logic [1:0]                  status
);
  import ise_pkg::*;

  ise_cmd_t  cmd;
  ise_stat_t st;

  ise_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  ise_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .func         (func),
    .req_begin    (req_begin),
    .req_end      (req_end),
    .sel_type     (sel_type),
    .entry_index  (entry_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .range_count  (range_count),
    .point_total  (point_total),
    .read_begin   (read_begin),
    .read_end     (read_end),
    .is_contained (is_contained),
    .status       (status)
  );

  // range count never exceeds the table size
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> range_count <= CNT_W'(MAX_RANGES))
    else $error("range count above table size");

  // a captured request keeps the input closed next cycle
  a_capture_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> !in_ready)
    else $error("input reopened right after capture");

  // bad index result carries a zero entry
  a_bad_idx_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_BAD_IDX) |-> (read_begin == '0 && read_end == '0))
    else $error("bad index result with nonzero entry");

  // containment only reported on a clean request
  a_cont_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_contained) |-> status == ST_OK)
    else $error("containment with error status");

endmodule

// ===== verif/interval_set_engine_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_set_engine_top_tb: self-checking bench for the interval set engine
// A directed table of requests (extremes, every request code, error cases)
// is followed by random request streams clustered on a small index window so
// that merges, splits and table-full drops occur often. Each result is
// checked field by field against a range-table model or a row's typed result.
// ----------------------------------------------------------------------------
module interval_set_engine_top_tb;
  import ise_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

  typedef struct {
    logic [2:0]       func;
    logic [IDX_W-1:0] rb;
    logic [IDX_W-1:0] re;
    logic [2:0]       sel;
    logic [3:0]       idx;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [IDX_W-1:0] pts;
    logic [IDX_W-1:0] rd_b;
    logic [IDX_W-1:0] rd_e;
    logic             cont;
    logic [1:0]       st;
  } rsp_t;

  // directed row: request, plus an optional typed-in result
  typedef struct {
    req_t r;
    bit   has_rsp;
    rsp_t x;
  } row_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [2:0] func, sel_type;
  logic [IDX_W-1:0] req_begin, req_end;
  logic [3:0] entry_index;
  logic [CNT_W-1:0] range_count;
  logic [IDX_W-1:0] point_total, read_begin, read_end;
  logic is_contained;
  logic [1:0] status;

  interval_set_engine_top u_top (.*);

  // model of the range table
  logic [63:0] tbl_b [MAX_RANGES];
  logic [63:0] tbl_e [MAX_RANGES];
  int unsigned tbl_n;

  rsp_t expected_rsp_q [$];
  int   fail_cnt;
  bit   no_idle;
  int   cyc;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc > LIMIT_CYCLES) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    logic [63:0] b, e, nb, ne, s;
    logic [63:0] tb [MAX_RANGES];
    logic [63:0] te [MAX_RANGES];
    int unsigned lo, hi, k;
    bit split;
    o = '{default: '0};
    b = r.rb;
    e = r.re;
    case (r.func)
      FUNC_ADD: begin
        if (e < b) o.st = ST_INVALID;
        else if (e > b) begin
          lo = 0;
          while (lo < tbl_n && tbl_e[lo] < b) lo++;
          hi = lo;
          while (hi < tbl_n && tbl_b[hi] <= e) hi++;
          nb = b; ne = e;
          if (hi > lo) begin
            if (tbl_b[lo] < nb) nb = tbl_b[lo];
            if (tbl_e[hi-1] > ne) ne = tbl_e[hi-1];
          end
          if (tbl_n - (hi - lo) + 1 > MAX_RANGES) o.st = ST_FULL;
          else begin
            k = 0;
            for (int i = 0; i < lo; i++) begin
              tb[k] = tbl_b[i]; te[k] = tbl_e[i]; k++;
            end
            tb[k] = nb; te[k] = ne; k++;
            for (int i = hi; i < tbl_n; i++) begin
              tb[k] = tbl_b[i]; te[k] = tbl_e[i]; k++;
            end
            for (int i = 0; i < k; i++) begin
              tbl_b[i] = tb[i]; tbl_e[i] = te[i];
            end
            tbl_n = k;
          end
        end
      end
      FUNC_SUB: begin
        if (e < b) o.st = ST_INVALID;
        else if (e > b) begin
          split = 0;
          for (int i = 0; i < tbl_n; i++)
            if (tbl_b[i] < b && tbl_e[i] > e && tbl_n >= MAX_RANGES) split = 1;
          if (split) o.st = ST_FULL;
          else begin
            k = 0;
            for (int i = 0; i < tbl_n; i++) begin
              if (tbl_e[i] <= b || tbl_b[i] >= e) begin
                tb[k] = tbl_b[i]; te[k] = tbl_e[i]; k++;
              end else begin
                if (tbl_b[i] < b && k < MAX_RANGES) begin
                  tb[k] = tbl_b[i]; te[k] = b; k++;
                end
                if (tbl_e[i] > e && k < MAX_RANGES) begin
                  tb[k] = e; te[k] = tbl_e[i]; k++;
                end
              end
            end
            for (int i = 0; i < k; i++) begin
              tbl_b[i] = tb[i]; tbl_e[i] = te[i];
            end
            tbl_n = k;
          end
        end
      end
      FUNC_CLEAR: tbl_n = 0;
      FUNC_ENFORCE: begin
        if (r.sel == SEL_NONE) tbl_n = 0;
        else if (r.sel == SEL_SINGLE) begin
          if (tbl_n > 0) begin
            tbl_n = 1;
            if (tbl_e[0] - tbl_b[0] > 1) tbl_e[0] = tbl_b[0] + 1;
          end
        end else if (r.sel == SEL_RANGE) begin
          if (tbl_n > 1) begin
            tbl_e[0] = tbl_e[tbl_n-1];
            tbl_n = 1;
          end
        end
      end
      FUNC_READ: begin
        if (r.idx < tbl_n) begin
          o.rd_b = tbl_b[r.idx][IDX_W-1:0];
          o.rd_e = tbl_e[r.idx][IDX_W-1:0];
        end else o.st = ST_BAD_IDX;
      end
      FUNC_CONT: begin
        if (e < b) o.st = ST_INVALID;
        else if (e > b)
          for (int i = 0; i < tbl_n; i++)
            if (tbl_b[i] <= b && tbl_e[i] >= e) o.cont = 1'b1;
      end
      default: ;
    endcase
    s = 0;
    for (int i = 0; i < tbl_n; i++) s += tbl_e[i] - tbl_b[i];
    o.cnt = tbl_n[CNT_W-1:0];
    o.pts = s[IDX_W-1:0];
    return o;
  endfunction

  // one request on the input channel, with an optional idle burst first;
  // valid stays high after acceptance until the next request or an idle
  task automatic send_request(req_t r, bit has_rsp, rsp_t x);
    rsp_t p;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    p = apply_request(r);
    if (has_rsp && p != x)
      $display("directed row disagrees with model: func %0d", r.func);
    expected_rsp_q.push_back(has_rsp ? x : p);
    in_valid    <= 1'b1;
    func        <= r.func;
    req_begin   <= r.rb;
    req_end     <= r.re;
    sel_type    <= r.sel;
    entry_index <= r.idx;
    do @(posedge clk); while (!in_ready);
  endtask

  // receiver stalls in random bursts
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    rsp_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{range_count, point_total, read_begin, read_end, is_contained, status};
      if (expected_rsp_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_rsp_q.pop_front();
        if (got != want) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  function automatic req_t mk(logic [2:0] f, logic [IDX_W-1:0] b, logic [IDX_W-1:0] e,
                              logic [2:0] s, logic [3:0] i);
    req_t r;
    r = '{f, b, e, s, i};
    return r;
  endfunction

  function automatic rsp_t rs(int c, int p, logic [1:0] st);
    rsp_t x;
    x = '{c[CNT_W-1:0], p[IDX_W-1:0], '0, '0, 1'b0, st};
    return x;
  endfunction

  // random request, clustered on a small window for frequent overlaps unless wide
  function automatic req_t rand_request(int wide);
    req_t r;
    logic [IDX_W-1:0] b, e;
    int w;
    w = wide ? 0 : 200;
    r.func = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(2, 7))
                                          : 3'($urandom_range(0, 5));
    if (w == 0) begin
      b = IDX_W'($urandom); e = IDX_W'($urandom);
    end else begin
      b = IDX_W'($urandom_range(0, w));
      e = b + IDX_W'($urandom_range(0, 12));
      if ($urandom_range(0, 15) == 0) e = IDX_W'($urandom_range(0, w));
    end
    r.rb  = b;
    r.re  = e;
    r.sel = 3'($urandom);
    r.idx = 4'($urandom);
    if (r.func == FUNC_CLEAR && $urandom_range(0, 3) != 0) r.func = FUNC_ADD;
    if (r.func == FUNC_ENFORCE && $urandom_range(0, 2) != 0) r.func = FUNC_SUB;
    return r;
  endfunction

  initial begin
    row_t rows [$];
    rsp_t none;
    req_t r;
    none = '{default: '0};
    fail_cnt = 0; no_idle = 0;
    tbl_n = 0;
    rst = 1'b1;
    in_valid = 1'b0; func = '0; req_begin = '0; req_end = '0;
    sel_type = '0; entry_index = '0;

    rows.push_back('{mk(FUNC_READ, 0, 0, 0, 0), 1, rs(0, 0, ST_BAD_IDX)});
    rows.push_back('{mk(FUNC_ADD, 5, 4, 0, 0), 1, rs(0, 0, ST_INVALID)});
    rows.push_back('{mk(FUNC_ADD, 7, 7, 0, 0), 1, rs(0, 0, ST_OK)});
    rows.push_back('{mk(FUNC_ADD, 0, IDX_MAX, 0, 0), 1, rs(1, IDX_MAX, ST_OK)});
    rows.push_back('{mk(FUNC_READ, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(FUNC_CONT, 0, IDX_MAX, 0, 0), 0, none});
    rows.push_back('{mk(FUNC_CONT, 3, 3, 0, 0), 0, none});
    rows.push_back('{mk(FUNC_CONT, IDX_MAX, 0, 0, 0), 0, none});
    rows.push_back('{mk(FUNC_SUB, 10, 20, 0, 0), 0, none});
    rows.push_back('{mk(FUNC_SUB, 9, 2, 0, 0), 0, none});
    rows.push_back('{mk(FUNC_SUB, 0, 5, 0, 0), 0, none});
    rows.push_back('{mk(FUNC_ENFORCE, 0, 0, SEL_RANGE, 0), 0, none});
    rows.push_back('{mk(FUNC_ENFORCE, 0, 0, SEL_SINGLE, 0), 0, none});
    rows.push_back('{mk(FUNC_ENFORCE, 0, 0, 3'd1, 0), 0, none});
    rows.push_back('{mk(FUNC_ENFORCE, 0, 0, 3'd4, 0), 0, none});
    rows.push_back('{mk(FUNC_ENFORCE, 0, 0, 3'd7, 0), 0, none});
    rows.push_back('{mk(FUNC_ENFORCE, 0, 0, SEL_NONE, 0), 1, rs(0, 0, ST_OK)});
    rows.push_back('{mk(3'd6, 1, 2, 0, 0), 1, rs(0, 0, ST_OK)});
    rows.push_back('{mk(3'd7, 1, 2, 0, 0), 1, rs(0, 0, ST_OK)});
    // fill the table with 16 separated ranges of three points, then overflow it
    for (int i = 0; i < 16; i++)
      rows.push_back('{mk(FUNC_ADD, IDX_W'(4*i), IDX_W'(4*i+3), 0, 0), 0, none});
    rows.push_back('{mk(FUNC_ADD, 100, 101, 0, 0), 1, rs(16, 48, ST_FULL)});
    // split of the first range while full
    rows.push_back('{mk(FUNC_SUB, 1, 2, 0, 0), 1, rs(16, 48, ST_FULL)});
    rows.push_back('{mk(FUNC_READ, 0, 0, 0, 15), 0, none});
    rows.push_back('{mk(FUNC_ADD, 2, 4, 0, 0), 0, none});
    rows.push_back('{mk(FUNC_CLEAR, 0, 0, 0, 0), 1, rs(0, 0, ST_OK)});

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_request(rows[i].r, rows[i].has_rsp, rows[i].x);

    for (int n = 0; n < 1400; n++) begin
      if (n == 700) begin
        // hold off until the engine has drained
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_rsp_q.size() != 0);
        r = mk(FUNC_CLEAR, 0, 0, 0, 0);
        send_request(r, 0, none);
      end
      if (n == 1200) no_idle = 1;
      send_request(rand_request($urandom_range(0, 40) == 0), 0, none);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (expected_rsp_q.size() != 0);
    repeat (50) @(posedge clk);
    if (fail_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
